// ===== design/dstq_pkg.sv =====
package dstq_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TAG_W   = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_TICK_DONE = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD_SAT = 2'd0,
    ALU_LE      = 2'd1,
    ALU_EQ      = 2'd2
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_REM_RD,
    S_REM_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TICK_RD,
    S_TICK_CMP
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              flag;
  } alu_rsp_t;

  typedef struct packed {
    status_e           status;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } res_t;

  function automatic res_t mk_res(status_e st, logic [KIND_W-1:0] k,
                                  logic [TAG_W-1:0] t, logic l);
    res_t r;
    r.status = st;
    r.kind   = k;
    r.tag    = t;
    r.last   = l;
    return r;
  endfunction

endpackage

// ===== design/dstq_alu.sv =====
module dstq_alu (
  input  dstq_pkg::alu_req_t req_i,
  output dstq_pkg::alu_rsp_t rsp_o
);
  import dstq_pkg::*;

  logic [TIME_W:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, req_i.b};

  always_comb begin
    rsp_o.res  = '0;
    rsp_o.flag = 1'b0;
    case (req_i.op)
      ALU_ADD_SAT: begin
        // clamp at the top of the time range
        rsp_o.res  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        rsp_o.flag = sum[TIME_W];
      end
      ALU_LE: begin
        rsp_o.flag = (req_i.a <= req_i.b);
      end
      ALU_EQ: begin
        rsp_o.flag = (req_i.a == req_i.b);
      end
      default: begin
        rsp_o.res  = '0;
        rsp_o.flag = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/dstq_table.sv =====
module dstq_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IW-1:0]    rd_addr_i,
  output dstq_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  dstq_pkg::entry_t wr_data_i
);
  import dstq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/deadline_sorted_task_queue.sv =====
// Sorted task queue: one command at a time, start taken while busy is low.
// Insert scans from the tail, moving later entries down, and answers at once when
// full; remove scans from the head for the tag, then moves later entries up, and
// answers not found at the tail; a tick gives one expired word per entry leaving the
// head, then a final word. The next command is taken at the edge that ends the
// final word. The receiver cannot stall. Reset clears time, count and control only.
module deadline_sorted_task_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  task_kind_i,
  input  logic [23:0] delay_ms_i,
  input  logic [15:0] tag_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [1:0]  out_kind_o,
  output logic [15:0] out_tag_o,
  output logic        last_o
);
  import dstq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [TIME_W-1:0]  dl_q, dl_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [KIND_W-1:0]  hit_kind_q, hit_kind_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  logic [CW-1:0] idx_nx;
  logic          at_tail;

  assign idx_nx  = CW'(idx_q) + CW'(1);
  assign at_tail = (idx_nx == cnt_q);

  dstq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  dstq_table #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    kind_q     <= kind_d;
    delay_q    <= delay_d;
    tag_q      <= tag_d;
    dl_q       <= dl_d;
    idx_q      <= idx_d;
    hit_kind_q <= hit_kind_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    kind_d      = kind_q;
    delay_d     = delay_q;
    tag_d       = tag_q;
    dl_d        = dl_q;
    now_d       = now_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    hit_kind_d  = hit_kind_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    alu_req.op  = ALU_LE;
    alu_req.a   = rd_data.deadline;
    alu_req.b   = dl_q;

    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_data;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = op_e'(operation_i);
          kind_d  = task_kind_i;
          delay_d = delay_ms_i;
          tag_d   = tag_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (op_q)
          OP_INSERT: begin
            alu_req.op = ALU_ADD_SAT;
            alu_req.a  = now_q;
            alu_req.b  = TIME_W'(delay_q);
            dl_d       = alu_rsp.res;
            if (cnt_q == CW'(DEPTH)) begin
              res_valid_d = 1'b1;
              res_d       = mk_res(ST_FULL, '0, '0, 1'b1);
              state_d     = S_IDLE;
            end else if (cnt_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_WR;
            end else begin
              // scan from the tail, moving later deadlines down one place
              idx_d   = IW'(cnt_q - CW'(1));
              state_d = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            if (tag_q == '0 || cnt_q == '0) begin
              res_valid_d = 1'b1;
              res_d       = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
              state_d     = S_IDLE;
            end else begin
              idx_d   = '0;
              state_d = S_REM_RD;
            end
          end
          OP_TICK: begin
            alu_req.op = ALU_ADD_SAT;
            alu_req.a  = now_q;
            alu_req.b  = TIME_W'(1);
            now_d      = alu_rsp.res;
            state_d    = S_TICK_RD;
          end
          default: begin
            cnt_d       = '0;
            res_valid_d = 1'b1;
            res_d       = mk_res(ST_CLEARED, '0, '0, 1'b1);
            state_d     = S_IDLE;
          end
        endcase
      end

      S_INS_RD: begin
        rd_en   = 1'b1;
        state_d = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (alu_rsp.flag) begin
          idx_d   = IW'(idx_nx);
          state_d = S_INS_WR;
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(idx_nx);
          if (idx_q == '0) begin
            state_d = S_INS_WR;
          end else begin
            idx_d   = idx_q - IW'(1);
            state_d = S_INS_RD;
          end
        end
      end

      S_INS_WR: begin
        wr_en            = 1'b1;
        wr_data.deadline = dl_q;
        wr_data.kind     = kind_q;
        wr_data.tag      = tag_q;
        cnt_d            = cnt_q + CW'(1);
        res_valid_d      = 1'b1;
        res_d            = mk_res(ST_INSERTED, '0, '0, 1'b1);
        state_d          = S_IDLE;
      end

      S_REM_RD: begin
        rd_en   = 1'b1;
        state_d = S_REM_CMP;
      end

      S_REM_CMP: begin
        alu_req.op = ALU_EQ;
        alu_req.a  = TIME_W'(rd_data.tag);
        alu_req.b  = TIME_W'(tag_q);
        if (alu_rsp.flag) begin
          hit_kind_d = rd_data.kind;
          state_d    = S_SHIFT_RD;
        end else if (at_tail) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(ST_NOT_FOUND, '0, '0, 1'b1);
          state_d     = S_IDLE;
        end else begin
          idx_d   = IW'(idx_nx);
          state_d = S_REM_RD;
        end
      end

      // close the gap at idx by moving every later word up one place
      S_SHIFT_RD: begin
        if (at_tail) begin
          cnt_d = cnt_q - CW'(1);
          if (op_q == OP_REMOVE) begin
            res_valid_d = 1'b1;
            res_d       = mk_res(ST_REMOVED, hit_kind_q, tag_q, 1'b1);
            state_d     = S_IDLE;
          end else begin
            state_d = S_TICK_RD;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(idx_nx);
          state_d = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        idx_d   = IW'(idx_nx);
        state_d = S_SHIFT_RD;
      end

      S_TICK_RD: begin
        if (cnt_q == '0) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(ST_TICK_DONE, '0, '0, 1'b1);
          state_d     = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_TICK_CMP;
        end
      end

      S_TICK_CMP: begin
        alu_req.b = now_q;
        if (alu_rsp.flag) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(ST_EXPIRED, rd_data.kind, rd_data.tag, 1'b0);
          idx_d       = '0;
          state_d     = S_SHIFT_RD;
        end else begin
          res_valid_d = 1'b1;
          res_d       = mk_res(ST_TICK_DONE, '0, '0, 1'b1);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_q.status;
  assign out_kind_o     = res_q.kind;
  assign out_tag_o      = res_q.tag;
  assign last_o         = res_q.last;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer not busy");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> !busy)
    else $error("final word while command still running");

  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> busy)
    else $error("intermediate word with sequencer idle");

endmodule
